### hdl/pfad_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfad_pkg - shared types and constants of the page frame allocator
// Field widths, frame map sizing, directory layout and action codes.
// ---------------------------------------------------------------------------
package pfad_pkg;

	// physical frames managed by the used-frame map
	localparam int FRAME_COUNT = 32;
	localparam int FRAME_IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

	localparam int ACTION_W = 2;
	localparam int VPAGE_W  = 10;
	localparam int AMOUNT_W = 11;
	localparam int FRAME_W  = 10;
	localparam int FLAG_W   = 8;
	localparam int CNT_W    = 11;

	localparam int DIR_DEPTH = 1024;
	localparam int DIR_AW    = $clog2(DIR_DEPTH);
	localparam int ENTRY_W   = FRAME_W + FLAG_W;

	localparam int IN_BITS   = ACTION_W + VPAGE_W + AMOUNT_W + FRAME_W + FLAG_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 1 + FRAME_W + CNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CNT_W-1:0] FRAME_COUNT_C = CNT_W'(FRAME_COUNT);

	// flags, bit 0 up: present, rw, user, pwt, pcd, accessed, dirty, ps (4 MB)
	localparam logic [FLAG_W-1:0] FLAG_ALL        = 8'hFF;
	localparam logic [FLAG_W-1:0] FLAG_USER_MASK  = 8'h87;
	localparam int                FLAG_PRESENT_BIT = 0;

	localparam logic [DIR_AW-1:0] KERNEL_LOW_ENTRY  = DIR_AW'(0);
	localparam logic [DIR_AW-1:0] KERNEL_HIGH_ENTRY = DIR_AW'(12'h300);

	typedef enum logic [ACTION_W-1:0] {
		ACT_CHECK = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2,
		ACT_SET   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// request from the sequencer to the frame map
	typedef struct packed {
		logic               alloc;    // mark first free frame used, count down
		logic               dealloc;  // clear rel_frame, count up
		logic [FRAME_W-1:0] rel_frame;
	} map_cmd_t;

	typedef struct packed {
		logic                   found;      // a free frame exists
		logic [FRAME_IDX_W-1:0] first_free; // lowest free frame
		logic [CNT_W-1:0]       free_cnt;
		logic [CNT_W-1:0]       free_cnt_next;
	} map_status_t;

endpackage
`default_nettype wire

### hdl/pfad_dir_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfad_dir_ram - page directory storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pfad_dir_ram (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [pfad_pkg::DIR_AW-1:0]  wr_addr,
	input  wire logic [pfad_pkg::ENTRY_W-1:0] wr_data,
	input  wire logic                         rd_en,
	input  wire logic [pfad_pkg::DIR_AW-1:0]  rd_addr,
	output logic      [pfad_pkg::ENTRY_W-1:0] rd_data
);

	logic [pfad_pkg::ENTRY_W-1:0] mem [pfad_pkg::DIR_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### hdl/pfad_frame_map.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfad_frame_map - used-frame bitmap and free-frame counter
// Keeps the lowest free frame registered for the next allocation.
// ---------------------------------------------------------------------------
module pfad_frame_map (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pfad_pkg::map_cmd_t     cmd,
	output pfad_pkg::map_status_t       status
);

	logic [pfad_pkg::FRAME_COUNT-1:0] used_q;
	logic [pfad_pkg::CNT_W-1:0]       cnt_q;
	logic [pfad_pkg::FRAME_IDX_W-1:0] ff_idx_q;
	logic                             ff_found_q;

	logic [pfad_pkg::FRAME_IDX_W-1:0] ff_idx;
	logic                             ff_found;
	logic                             rel_in_range;
	logic [pfad_pkg::CNT_W-1:0]       cnt_next;

	// lowest clear bit; scanned high to low so the lowest wins
	always_comb begin
		ff_idx   = '0;
		ff_found = 1'b0;
		for (int i = pfad_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				ff_idx   = pfad_pkg::FRAME_IDX_W'(i);
				ff_found = 1'b1;
			end
		end
	end

	assign rel_in_range = {1'b0, cmd.rel_frame} < pfad_pkg::FRAME_COUNT_C;

	always_comb begin
		cnt_next = cnt_q;
		if (cmd.alloc && (cnt_q != '0)) begin
			cnt_next = cnt_q - 1'b1;
		end else if (cmd.dealloc && (cnt_q < pfad_pkg::FRAME_COUNT_C)) begin
			cnt_next = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= pfad_pkg::FRAME_COUNT'(1);
			cnt_q      <= pfad_pkg::FRAME_COUNT_C - 1'b1;
			ff_idx_q   <= '0;
			ff_found_q <= 1'b0;
		end else begin
			if (cmd.alloc) begin
				used_q[ff_idx_q] <= 1'b1;
			end else if (cmd.dealloc && rel_in_range) begin
				used_q[cmd.rel_frame[pfad_pkg::FRAME_IDX_W-1:0]] <= 1'b0;
			end
			cnt_q      <= cnt_next;
			ff_idx_q   <= ff_idx;
			ff_found_q <= ff_found;
		end
	end

	assign status.found         = ff_found_q;
	assign status.first_free    = ff_idx_q;
	assign status.free_cnt      = cnt_q;
	assign status.free_cnt_next = cnt_next;

endmodule
`default_nettype wire

### hdl/page_frame_allocator_with_directory_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// page_frame_allocator_with_directory_core - first-fit frame allocator
// Used-frame bitmap, free count and a 1024-entry 4 MB page directory.
// ---------------------------------------------------------------------------
// Usage:
//  - Requests enter on the s_t* stream: action, virtual page, amount,
//    physical frame and entry flags. One result item per request leaves on
//    the m_t* stream: ok, frame and the free count after the action.
//  - The idle state takes an item and reads its entry from the synchronous
//    RAM; the execute step modifies it, writes it back and updates the map.
//    Due to this read-modify-write no new item is taken until it ends.
//  - The lowest free frame is searched each cycle and registered, so
//    allocation only indexes the bitmap.
//  - m_tvalid rises once the execute step has registered the result.
//  - After reset the directory is swept once, one entry per cycle, writing
//    the reset image (entries 0 and 0x300 with all flags set, others zero),
//    during which s_tready stays low.
//  - Results sit in an output register; a new item is accepted while one
//    waits. If the receiver still stalls when the next item completes, the
//    block holds that item in its execute step until m_tready frees the
//    register; nothing is dropped.
// ---------------------------------------------------------------------------
module page_frame_allocator_with_directory_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// action[1:0], virtual_page[11:2], amount[22:12], phys_frame[32:23],
	// entry_flags[40:33], zero fill
	input  wire logic [pfad_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// ok[0], frame[10:1], free_count[21:11], zero fill
	output logic      [pfad_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int VP_LO = pfad_pkg::ACTION_W;
	localparam int AM_LO = VP_LO + pfad_pkg::VPAGE_W;
	localparam int PF_LO = AM_LO + pfad_pkg::AMOUNT_W;
	localparam int FL_LO = PF_LO + pfad_pkg::FRAME_W;

	pfad_pkg::state_t state_q, state_next;

	logic [pfad_pkg::DIR_AW-1:0] clr_cnt_q;

	// request held for the execute step
	pfad_pkg::action_t            act_s1;
	logic [pfad_pkg::VPAGE_W-1:0]  vpage_s1;
	logic [pfad_pkg::AMOUNT_W-1:0] amount_s1;
	logic [pfad_pkg::FRAME_W-1:0]  pframe_s1;
	logic [pfad_pkg::FLAG_W-1:0]   flags_s1;

	// output register
	logic                          out_valid_q;
	logic                          ok_q;
	logic [pfad_pkg::FRAME_W-1:0]  frame_q;
	logic [pfad_pkg::CNT_W-1:0]    cnt_q;

	logic                           accept;
	logic                           out_free;
	logic                           exec_go;
	logic                           clr_last;

	logic                           dir_we;
	logic [pfad_pkg::DIR_AW-1:0]    dir_waddr;
	logic [pfad_pkg::ENTRY_W-1:0]   dir_wdata;
	logic [pfad_pkg::ENTRY_W-1:0]   dir_rdata;

	pfad_pkg::map_cmd_t    map_cmd;
	pfad_pkg::map_status_t map_st;

	logic                          res_ok;
	logic [pfad_pkg::FRAME_W-1:0]  res_frame;

	logic [pfad_pkg::FLAG_W-1:0]   rd_flags;
	logic [pfad_pkg::FRAME_W-1:0]  rd_frame;

	assign rd_flags = dir_rdata[pfad_pkg::FLAG_W-1:0];
	assign rd_frame = dir_rdata[pfad_pkg::ENTRY_W-1:pfad_pkg::FLAG_W];

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign clr_last = (clr_cnt_q == pfad_pkg::DIR_AW'(pfad_pkg::DIR_DEPTH - 1));

	// ---- sequencer: next state ----
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			pfad_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_next = pfad_pkg::ST_IDLE;
				end
			end
			pfad_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_next = pfad_pkg::ST_EXEC;
				end
			end
			pfad_pkg::ST_EXEC: begin
				if (out_free) begin
					state_next = pfad_pkg::ST_IDLE;
				end
			end
			default: state_next = pfad_pkg::ST_IDLE;
		endcase
	end

	// ---- sequencer: outputs ----
	always_comb begin
		s_tready  = 1'b0;
		exec_go   = 1'b0;
		dir_we    = 1'b0;
		dir_waddr = vpage_s1;
		dir_wdata = {pframe_s1, flags_s1};
		map_cmd   = '0;
		res_ok    = 1'b0;
		res_frame = '0;
		unique case (state_q)
			pfad_pkg::ST_CLEAR: begin
				dir_we    = 1'b1;
				dir_waddr = clr_cnt_q;
				if ((clr_cnt_q == pfad_pkg::KERNEL_LOW_ENTRY) ||
				    (clr_cnt_q == pfad_pkg::KERNEL_HIGH_ENTRY)) begin
					dir_wdata = {pfad_pkg::FRAME_W'(0), pfad_pkg::FLAG_ALL};
				end else begin
					dir_wdata = '0;
				end
			end
			pfad_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			pfad_pkg::ST_EXEC: begin
				exec_go = out_free;
				unique case (act_s1)
					pfad_pkg::ACT_CHECK: begin
						res_ok = (amount_s1 <= map_st.free_cnt);
					end
					pfad_pkg::ACT_ALLOC: begin
						if (map_st.found) begin
							dir_we        = exec_go;
							dir_wdata     = {pfad_pkg::FRAME_W'(map_st.first_free),
							                 rd_flags | pfad_pkg::FLAG_USER_MASK};
							map_cmd.alloc = exec_go;
							res_ok        = 1'b1;
							res_frame     = pfad_pkg::FRAME_W'(map_st.first_free);
						end
					end
					pfad_pkg::ACT_FREE: begin
						if (rd_flags[pfad_pkg::FLAG_PRESENT_BIT]) begin
							dir_we            = exec_go;
							dir_wdata         = {rd_frame, rd_flags & ~pfad_pkg::FLAG_USER_MASK};
							map_cmd.dealloc   = exec_go;
							map_cmd.rel_frame = rd_frame;
							res_ok            = 1'b1;
							res_frame         = rd_frame;
						end
					end
					pfad_pkg::ACT_SET: begin
						dir_we = exec_go;
						res_ok = 1'b1;
					end
					default: res_ok = 1'b0;
				endcase
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfad_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == pfad_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= pfad_pkg::action_t'(s_tdata[pfad_pkg::ACTION_W-1:0]);
			vpage_s1  <= s_tdata[VP_LO +: pfad_pkg::VPAGE_W];
			amount_s1 <= s_tdata[AM_LO +: pfad_pkg::AMOUNT_W];
			pframe_s1 <= s_tdata[PF_LO +: pfad_pkg::FRAME_W];
			flags_s1  <= s_tdata[FL_LO +: pfad_pkg::FLAG_W];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exec_go) begin
			ok_q    <= res_ok;
			frame_q <= res_frame;
			cnt_q   <= map_st.free_cnt_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pfad_pkg::OUT_DATA_W'({cnt_q, frame_q, ok_q});

	pfad_dir_ram u_dir_ram (
		.clk     (clk),
		.wr_en   (dir_we),
		.wr_addr (dir_waddr),
		.wr_data (dir_wdata),
		.rd_en   (accept),
		.rd_addr (s_tdata[VP_LO +: pfad_pkg::VPAGE_W]),
		.rd_data (dir_rdata)
	);

	pfad_frame_map u_frame_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (map_cmd),
		.status (map_st)
	);

	// ---- assertions ----
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item accepted while the previous one is in flight");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == pfad_pkg::ST_EXEC))
		else $error("result shown without an execute step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		map_st.free_cnt <= pfad_pkg::FRAME_COUNT_C)
		else $error("free count above frame count");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfad_pkg::ST_IDLE) |-> !dir_we)
		else $error("directory written while idle");

endmodule
`default_nettype wire

### test/page_frame_allocator_with_directory_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_frame_allocator_with_directory_core_test - allocator stream test
// Feeds paging requests (check, allocate, free, set entry) and keeps a
// shadow of the frame bitmap, free count and page directory. Each result item
// is checked field by field against the shadow's answer, under rotating
// sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module page_frame_allocator_with_directory_core_test;
	import pfad_pkg::*;

	// no handshake for this long means the block has hung (covers the sweep)
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 550;
	localparam int PHASE_ITEMS    = 50;

	// packs straight onto s_tdata: action lowest, flags highest
	typedef struct packed {
		logic [FLAG_W-1:0]   flags;
		logic [FRAME_W-1:0]  pframe;
		logic [AMOUNT_W-1:0] amount;
		logic [VPAGE_W-1:0]  vpage;
		action_t             action;
	} page_request_t;

	// matches m_tdata: ok lowest, free count highest
	typedef struct packed {
		logic [CNT_W-1:0]   free_count;
		logic [FRAME_W-1:0] frame;
		logic               ok;
	} frame_outcome_t;

	typedef enum logic [1:0] {
		LOAD_FULL,
		LOAD_SRC_GAPS,
		LOAD_SINK_STALLS,
		LOAD_BOTH
	} load_phase_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	page_request_t  request_backlog[$];
	frame_outcome_t due_outcomes[$];
	page_request_t  on_bus;

	// shadow of the block's state
	logic                 frame_busy[FRAME_COUNT];
	logic [CNT_W-1:0]     frames_left;
	logic [ENTRY_W-1:0]   dir_shadow[DIR_DEPTH];

	load_phase_t load_phase  = LOAD_FULL;
	int          sent_items  = 0;
	int          mismatches  = 0;
	int          idle_cycles = 0;
	int unsigned gap_pct[4]   = '{0, 45, 0, 15};
	int unsigned stall_pct[4] = '{0, 0, 45, 15};

	page_frame_allocator_with_directory_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one request to the shadow state and returns the result item it
	// should produce.
	function automatic frame_outcome_t resolve_request(input page_request_t r);
		frame_outcome_t     res;
		logic [ENTRY_W-1:0] ent;
		logic [FRAME_W-1:0] fr;
		int                 i;
		int                 lowest;
		res = '0;
		ent = dir_shadow[r.vpage];
		case (r.action)
		ACT_CHECK: begin
			res.ok = (r.amount <= frames_left);
		end
		ACT_ALLOC: begin
			lowest = FRAME_COUNT;
			for (i = FRAME_COUNT - 1; i >= 0; i--)
				if (!frame_busy[i])
					lowest = i;
			// nothing free: fail and leave everything as it was
			if (lowest < FRAME_COUNT) begin
				frame_busy[lowest] = 1'b1;
				if (frames_left != 0)
					frames_left = frames_left - 1'b1;
				// other flags of the entry survive
				dir_shadow[r.vpage] = {FRAME_W'(lowest), ent[FLAG_W-1:0] | FLAG_USER_MASK};
				res.ok    = 1'b1;
				res.frame = FRAME_W'(lowest);
			end
		end
		ACT_FREE: begin
			if (ent[FLAG_PRESENT_BIT]) begin
				fr = ent[ENTRY_W-1:FLAG_W];
				// frame numbers past the map touch no bit but still count up
				if (fr < FRAME_COUNT)
					frame_busy[fr] = 1'b0;
				if (frames_left < FRAME_COUNT_C)
					frames_left = frames_left + 1'b1;
				dir_shadow[r.vpage] = {fr, ent[FLAG_W-1:0] & ~FLAG_USER_MASK};
				res.ok    = 1'b1;
				res.frame = fr;
			end
		end
		default: begin
			dir_shadow[r.vpage] = {r.pframe, r.flags};
			res.ok = 1'b1;
		end
		endcase
		res.free_count = frames_left;
		return res;
	endfunction

	// Mostly a small working set so frees find mapped entries; now and then
	// the kernel entries, the top entry or anywhere.
	function automatic logic [VPAGE_W-1:0] pick_vpage();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 80)
			return VPAGE_W'($urandom_range(47, 0));
		if (roll < 84)
			return KERNEL_LOW_ENTRY;
		if (roll < 88)
			return KERNEL_HIGH_ENTRY;
		if (roll < 90)
			return '1;
		return VPAGE_W'($urandom_range(DIR_DEPTH - 1, 0));
	endfunction

	function automatic page_request_t random_request(input action_t act);
		page_request_t r;
		r.action = act;
		r.vpage  = pick_vpage();
		r.amount = AMOUNT_W'($urandom_range(2047, 0));
		r.pframe = FRAME_W'($urandom_range(1023, 0));
		r.flags  = FLAG_W'($urandom_range(255, 0));
		return r;
	endfunction

	task automatic add_request(input action_t act, input logic [VPAGE_W-1:0] vp,
			input logic [AMOUNT_W-1:0] amt, input logic [FRAME_W-1:0] pf,
			input logic [FLAG_W-1:0] fl);
		request_backlog.push_back('{flags: fl, pframe: pf, amount: amt,
			vpage: vp, action: act});
	endtask

	// Driver: holds an item until taken, then offers the next unless the
	// current phase calls for a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				due_outcomes.push_back(resolve_request(on_bus));
				sent_items <= sent_items + 1;
				load_phase <= load_phase_t'(2'(((sent_items + 1) / PHASE_ITEMS) % 4));
			end
			if (!s_tvalid || s_tready) begin
				if (request_backlog.size() != 0 &&
						$urandom_range(99, 0) >= gap_pct[load_phase]) begin
					on_bus = request_backlog.pop_front();
					s_tdata  <= IN_DATA_W'(on_bus);
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each taken result item against the oldest expectation.
	always @(posedge clk) begin
		frame_outcome_t got;
		frame_outcome_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_BITS-1:0];
				if (due_outcomes.size() == 0) begin
					$error("unexpected result item: ok %0d frame %0d free_count %0d",
						got.ok, got.frame, got.free_count);
					mismatches++;
				end else begin
					want = due_outcomes.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						mismatches++;
					end
					if (got.frame !== want.frame) begin
						$error("frame: expected %0d, got %0d", want.frame, got.frame);
						mismatches++;
					end
					if (got.free_count !== want.free_count) begin
						$error("free_count: expected %0d, got %0d",
							want.free_count, got.free_count);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(99, 0) >= stall_pct[load_phase]);
		end
	end

	// Watchdog: no handshake on either side for too long ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("page_frame_allocator_with_directory_core test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		page_request_t r;
		int            i;
		int            n;
		int            total;

		// shadow reset image
		for (i = 0; i < DIR_DEPTH; i++)
			dir_shadow[i] = '0;
		for (i = 0; i < FRAME_COUNT; i++)
			frame_busy[i] = 1'b0;
		frame_busy[0] = 1'b1;
		frames_left = FRAME_COUNT_C - 1'b1;
		dir_shadow[KERNEL_LOW_ENTRY]  = {{FRAME_W{1'b0}}, FLAG_ALL};
		dir_shadow[KERNEL_HIGH_ENTRY] = {{FRAME_W{1'b0}}, FLAG_ALL};

		// directed: amount extremes around the free count
		add_request(ACT_CHECK, 10'd0, 11'd0, 10'd0, 8'h00);
		add_request(ACT_CHECK, 10'd0, AMOUNT_W'(FRAME_COUNT - 1), 10'd0, 8'h00);
		add_request(ACT_CHECK, 10'd0, AMOUNT_W'(FRAME_COUNT), 10'd0, 8'h00);
		add_request(ACT_CHECK, '1, '1, '1, '1);
		// free of an empty entry fails
		add_request(ACT_FREE, 10'd5, 11'd0, 10'd0, 8'h00);
		// kernel entries map frame 0: first free releases it, a repeat on the low entry fails
		// (present now clear) and the high entry is a double free; the count saturates at the frame count
		add_request(ACT_FREE, KERNEL_LOW_ENTRY, 11'd0, 10'd0, 8'h00);
		add_request(ACT_FREE, KERNEL_LOW_ENTRY, 11'd0, 10'd0, 8'h00);
		add_request(ACT_FREE, KERNEL_HIGH_ENTRY, 11'd0, 10'd0, 8'h00);
		// frame number beyond the map
		add_request(ACT_SET, '1, 11'd0, '1, FLAG_ALL);
		add_request(ACT_FREE, '1, 11'd0, 10'd0, 8'h00);
		// allocation keeps the entry's other flags
		add_request(ACT_SET, 10'd7, 11'd0, 10'h2AA, 8'h78);
		add_request(ACT_ALLOC, 10'd7, 11'd0, 10'd0, 8'h00);
		add_request(ACT_ALLOC, '1, 11'd0, 10'd0, 8'h00);
		add_request(ACT_SET, 10'd8, 11'd0, 10'd0, 8'h00);
		add_request(ACT_ALLOC, 10'd8, 11'd0, 10'd0, 8'h00);
		add_request(ACT_FREE, 10'd7, 11'd0, 10'd0, 8'h00);
		add_request(ACT_ALLOC, 10'd9, 11'd0, 10'd0, 8'h00);
		add_request(ACT_CHECK, 10'd0, AMOUNT_W'(FRAME_COUNT - 2), 10'd0, 8'h00);
		// set with present and the last frame of the map, then free it
		add_request(ACT_SET, 10'd10, 11'd0, FRAME_W'(FRAME_COUNT - 1), 8'h01);
		add_request(ACT_FREE, 10'd10, 11'd0, 10'd0, 8'h00);

		// random: bursts of well-formed work with some noise between
		total = request_backlog.size() + RANDOM_ITEMS;
		while (request_backlog.size() < total) begin
			case ($urandom_range(9, 0))
			0, 1, 2: begin
				// long enough bursts drain the map and hit the empty case
				n = $urandom_range(36, 4);
				repeat (n) request_backlog.push_back(random_request(ACT_ALLOC));
			end
			3, 4: begin
				n = $urandom_range(30, 4);
				repeat (n) request_backlog.push_back(random_request(ACT_FREE));
			end
			5: begin
				n = $urandom_range(8, 2);
				repeat (n) begin
					r = random_request(ACT_SET);
					if ($urandom_range(9, 0) < 7)
						r.flags[FLAG_PRESENT_BIT] = 1'b1;
					if ($urandom_range(9, 0) < 6)
						r.pframe = FRAME_W'($urandom_range(FRAME_COUNT - 1, 0));
					request_backlog.push_back(r);
				end
			end
			6, 7: begin
				n = $urandom_range(6, 1);
				repeat (n) begin
					r = random_request(ACT_CHECK);
					if ($urandom_range(9, 0) < 8)
						r.amount = AMOUNT_W'($urandom_range(FRAME_COUNT + 2, 0));
					request_backlog.push_back(r);
				end
			end
			default: begin
				n = $urandom_range(6, 1);
				repeat (n) begin
					r = random_request(action_t'(ACTION_W'($urandom_range(3, 0))));
					r.vpage = VPAGE_W'($urandom_range(DIR_DEPTH - 1, 0));
					request_backlog.push_back(r);
				end
			end
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || s_tvalid || due_outcomes.size() != 0)
			@(posedge clk);
		// keep clocking, so a stray extra result would show up
		repeat (8) @(posedge clk);
		if (due_outcomes.size() != 0) begin
			$error("%0d result items never arrived", due_outcomes.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("page_frame_allocator_with_directory_core test passed");
		else
			$display("page_frame_allocator_with_directory_core test failed");
		$finish;
	end

endmodule
